/* design/gtg_pkg.sv */
`timescale 1ns / 1ps

package gtg_pkg;

  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
  localparam logic [15:0] GAIN_RESET = 16'd128;
  localparam int unsigned SQRT_STAGES = 33;
  localparam int unsigned CW = 36;
  localparam int unsigned ZW = 18;
  localparam logic signed [ZW-1:0] HALF_PI_Q = 18'sd12868;
  localparam logic signed [18:0] PI_Q = 19'sd25736;
  localparam logic signed [18:0] TWO_PI_Q = 19'sd51472;

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
  } in_t;

  typedef struct packed {
    logic [31:0]        linear_drive;
    logic signed [15:0] angular_drive;
    logic               linear_saturated;
  } out_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] hd;
    logic               zero;
  } job_t;

  function automatic logic signed [ZW-1:0] atan_q(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 18'sd6434;
      1: v = 18'sd3798;
      2: v = 18'sd2007;
      3: v = 18'sd1019;
      4: v = 18'sd511;
      5: v = 18'sd256;
      6: v = 18'sd128;
      7: v = 18'sd64;
      8: v = 18'sd32;
      9: v = 18'sd16;
      10: v = 18'sd8;
      11: v = 18'sd4;
      12: v = 18'sd2;
      13: v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

/* design/gtg_front.sv */
`timescale 1ns / 1ps

module gtg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  gtg_pkg::in_t  req,
  output logic          job_valid,
  output gtg_pkg::job_t job
);

  gtg_pkg::job_t job_r, job_nxt;
  logic          valid_r;
  logic signed [32:0] dx, dy;

  always_comb begin
    dx = 33'(req.goal_x) - 33'(req.robot_x);
    dy = 33'(req.goal_y) - 33'(req.robot_y);
    job_nxt.dx = dx;
    job_nxt.dy = dy;
    job_nxt.hd = req.robot_heading;
    job_nxt.zero = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
    if (take) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = valid_r;
  assign job = job_r;

endmodule

/* design/gtg_queue.sv */
`timescale 1ns / 1ps

module gtg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gtg_pkg::job_t push_job,
  input  logic          pop,
  output logic          not_empty,
  output logic          full,
  output gtg_pkg::job_t pop_job
);

  gtg_pkg::job_t mem [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign full = (cnt_r == 2'd2);
  assign do_pop = pop && not_empty;
  assign pop_job = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
    if (push) begin
      mem[wp_r] <= push_job;
    end
  end

endmodule

/* design/gtg_back.sv */
`timescale 1ns / 1ps

module gtg_back #(
  parameter int unsigned ANGLE_ITERATIONS = gtg_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  gtg_pkg::job_t job,
  input  logic [15:0]   gain,
  output logic          res_valid,
  output gtg_pkg::out_t res
);

  localparam int unsigned NS = gtg_pkg::SQRT_STAGES;
  localparam int unsigned CW = gtg_pkg::CW;
  localparam int unsigned ZW = gtg_pkg::ZW;

  logic                 v_r    [0:NS];
  logic [65:0]          rad_r  [0:NS];
  logic [35:0]          rem_r  [0:NS];
  logic [32:0]          root_r [0:NS];
  logic signed [CW-1:0] x_r    [0:NS];
  logic signed [CW-1:0] y_r    [0:NS];
  logic signed [ZW-1:0] z_r    [0:NS];
  logic signed [15:0]   hd_r   [0:NS];
  logic                 zero_r [0:NS];

  logic [32:0] ax, ay;
  logic signed [CW-1:0] dxe, dye, x0, y0;
  logic signed [ZW-1:0] z0;

  always_comb begin
    ax = job.dx[32] ? 33'(-job.dx) : 33'(job.dx);
    ay = job.dy[32] ? 33'(-job.dy) : 33'(job.dy);
    dxe = CW'(job.dx);
    dye = CW'(job.dy);
    x0 = dxe;
    y0 = dye;
    z0 = '0;
    if (job.dx[32]) begin
      if (!job.dy[32]) begin
        x0 = dye;
        y0 = -dxe;
        z0 = gtg_pkg::HALF_PI_Q;
      end else begin
        x0 = -dye;
        y0 = dxe;
        z0 = -gtg_pkg::HALF_PI_Q;
      end
    end
  end

  // square and prerotate into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= job_valid;
    end
    rad_r[0] <= 66'(ax * ax) + 66'(ay * ay);
    rem_r[0] <= '0;
    root_r[0] <= '0;
    x_r[0] <= x0;
    y_r[0] <= y0;
    z_r[0] <= z0;
    hd_r[0] <= job.hd;
    zero_r[0] <= job.zero;
  end

  // one root bit per stage; one rotation per stage below ANGLE_ITERATIONS
  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [36:0] rem_t, trial;
    logic signed [CW-1:0] xn, yn;
    logic signed [ZW-1:0] zn;

    always_comb begin
      rem_t = {rem_r[j][34:0], rad_r[j][65:64]};
      trial = {2'b00, root_r[j][32:0], 2'b01};
      xn = x_r[j];
      yn = y_r[j];
      zn = z_r[j];
      if (j < ANGLE_ITERATIONS) begin
        if (!y_r[j][CW-1]) begin
          xn = x_r[j] + (y_r[j] >>> j);
          yn = y_r[j] - (x_r[j] >>> j);
          zn = z_r[j] + gtg_pkg::atan_q(j);
        end else begin
          xn = x_r[j] - (y_r[j] >>> j);
          yn = y_r[j] + (x_r[j] >>> j);
          zn = z_r[j] - gtg_pkg::atan_q(j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else begin
        v_r[j+1] <= v_r[j];
      end
      rad_r[j+1] <= {rad_r[j][63:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r[j+1] <= 36'(rem_t - trial);
        root_r[j+1] <= {root_r[j][31:0], 1'b1};
      end else begin
        rem_r[j+1] <= 36'(rem_t);
        root_r[j+1] <= {root_r[j][31:0], 1'b0};
      end
      x_r[j+1] <= xn;
      y_r[j+1] <= yn;
      z_r[j+1] <= zn;
      hd_r[j+1] <= hd_r[j];
      zero_r[j+1] <= zero_r[j];
    end
  end

  // scale by gain, wrap bearing
  logic               mv_r;
  logic [48:0]        lin_r;
  logic signed [15:0] ang_r;
  logic signed [18:0] diff, wrapped;

  always_comb begin
    diff = 19'(z_r[NS]) - 19'(hd_r[NS]);
    wrapped = diff;
    if (diff > gtg_pkg::PI_Q) begin
      wrapped = diff - gtg_pkg::TWO_PI_Q;
    end else if (diff <= -gtg_pkg::PI_Q) begin
      wrapped = diff + gtg_pkg::TWO_PI_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= v_r[NS];
    end
    lin_r <= 49'(gain) * 49'(root_r[NS]);
    ang_r <= zero_r[NS] ? 16'sd0 : 16'(wrapped);
  end

  // saturate and drive result
  logic          rv_r;
  gtg_pkg::out_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= mv_r;
    end
    if (|lin_r[48:40]) begin
      res_r.linear_drive <= '1;
      res_r.linear_saturated <= 1'b1;
    end else begin
      res_r.linear_drive <= lin_r[39:8];
      res_r.linear_saturated <= 1'b0;
    end
    res_r.angular_drive <= ang_r;
  end

  assign res_valid = rv_r;
  assign res = res_r;

endmodule

/* design/go_to_goal_pose_controller.sv */
`timescale 1ns / 1ps
// The result strobe follows a taken request through the front register,
// queue, square stage, 33 square-root/CORDIC stages, gain multiply, output.
// Throughput: one request per cycle; the pipeline never stalls, so busy only
// rises if the queue fills. The receiver cannot stall the result strobe.
// Reset (rst_n low, synchronous) empties the pipeline and sets the gain to 0.5.
module go_to_goal_pose_controller #(
  parameter int unsigned ANGLE_ITERATIONS = gtg_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gtg_pkg::in_t  in_req,
  output logic          out_valid,
  output gtg_pkg::out_t out_res,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_drive_gain
);

  logic [15:0]   gain_r;
  logic          take, fv, q_ne, q_full;
  gtg_pkg::job_t fjob, qjob;

  assign take = start && !busy;
  assign busy = q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= gtg_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_drive_gain;
    end
  end

  gtg_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .req(in_req),
    .job_valid(fv), .job(fjob)
  );

  gtg_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(fv), .push_job(fjob),
    .pop(1'b1), .not_empty(q_ne), .full(q_full), .pop_job(qjob)
  );

  gtg_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_ne), .job(qjob), .gain(gain_r),
    .res_valid(out_valid), .res(out_res)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = 37;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_RANDOM = 1430;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  gtg_pkg::in_t in_req;
  logic out_valid;
  gtg_pkg::out_t out_res;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_drive_gain;

  go_to_goal_pose_controller u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_drive_gain(cfg_drive_gain)
  );

  typedef struct {
    gtg_pkg::in_t req;
    logic has_expect;
    gtg_pkg::out_t result;
  } stim_row_t;

  logic [15:0] gain_model;
  gtg_pkg::out_t drive_queue[$];
  int errors;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [32:0] isqrt_radicand(input logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [32:0] root;
    rem = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | 68'(v[2*k +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 33'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic int bearing_of(input longint dx, input longint dy);
    longint x, y, t;
    int z;
    int atan_tab[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    x = dx;
    y = dy;
    z = 0;
    if (dx < 0) begin
      if (dy >= 0) begin
        x = dy; y = -dx; z = 12868;
      end else begin
        x = -dy; y = dx; z = -12868;
      end
    end
    for (int i = 0; i < gtg_pkg::ANGLE_ITERATIONS_DEF; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += (i < 14) ? atan_tab[i] : 0;
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= (i < 14) ? atan_tab[i] : 0;
      end
      x = t;
    end
    return z;
  endfunction

  function automatic gtg_pkg::out_t predict_drive(input gtg_pkg::in_t r);
    gtg_pkg::out_t o;
    longint dx, dy;
    logic [65:0] radicand;
    logic [32:0] distance;
    logic [48:0] lin;
    int ang;
    dx = longint'(r.goal_x) - longint'(r.robot_x);
    dy = longint'(r.goal_y) - longint'(r.robot_y);
    radicand = 66'(dx * dx) + 66'(dy * dy);
    distance = isqrt_radicand(radicand);
    lin = (49'(gain_model) * 49'(distance)) >> 8;
    o.linear_saturated = (lin > 49'hFFFF_FFFF);
    o.linear_drive = o.linear_saturated ? 32'hFFFF_FFFF : lin[31:0];
    ang = 0;
    if (dx != 0 || dy != 0) begin
      ang = bearing_of(dx, dy) - int'(r.robot_heading);
      while (ang > 25736) ang -= 51472;
      while (ang <= -25736) ang += 51472;
    end
    o.angular_drive = 16'(ang);
    return o;
  endfunction

  always @(posedge clk) begin
    gtg_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (drive_queue.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = drive_queue.pop_front();
        if (out_res.linear_drive !== want.linear_drive)
          report_mismatch("linear_drive", out_res.linear_drive, want.linear_drive);
        if (out_res.angular_drive !== want.angular_drive)
          report_mismatch("angular_drive", out_res.angular_drive, want.angular_drive);
        if (out_res.linear_saturated !== want.linear_saturated)
          report_mismatch("linear_saturated", out_res.linear_saturated,
                          want.linear_saturated);
      end
    end
  end

  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic drain_results();
    while (drive_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_gain(input logic [15:0] g);
    cfg_valid <= 1'b1;
    cfg_drive_gain <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gain_model = g;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold start until taken; expectation queued at the accepting edge
  task automatic send_request(input gtg_pkg::in_t r, input logic has_expect,
                              input gtg_pkg::out_t direct);
    if (idle_pct > 0) begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (has_expect) drive_queue.push_back(direct);
    else drive_queue.push_back(predict_drive(r));
    @(negedge clk);
  endtask

  function automatic gtg_pkg::in_t random_request(input int shape);
    gtg_pkg::in_t r;
    r.robot_x = $urandom;
    r.robot_y = $urandom;
    r.goal_x = $urandom;
    r.goal_y = $urandom;
    r.robot_heading = 16'($urandom_range(51472) - 25736);
    case (shape)
      0: begin
        r.goal_x = r.robot_x + $signed($urandom_range(2000) - 1000);
        r.goal_y = r.robot_y + $signed($urandom_range(2000) - 1000);
      end
      1: begin
        r.goal_x = r.robot_x + ($signed($urandom) >>> $urandom_range(31));
        r.goal_y = r.robot_y + ($signed($urandom) >>> $urandom_range(31));
      end
      2: r.robot_heading = 16'($urandom);
      3: begin
        r.goal_x = r.robot_x;
        if ($urandom_range(1)) r.goal_y = r.robot_y;
      end
      default: ;
    endcase
    return r;
  endfunction

  stim_row_t directed[$];
  gtg_pkg::out_t zero_res;

  initial begin
    gtg_pkg::in_t r;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_drive_gain = '0;
    errors = 0;
    idle_pct = 0;
    gain_model = gtg_pkg::GAIN_RESET;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    zero_res = '0;
    r = '0;
    directed.push_back('{r, 1'b1, zero_res});
    r.robot_heading = 16'sd25736;
    directed.push_back('{r, 1'b1, zero_res});
    r.goal_x = 32'sd65536;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.goal_x = -32'sd65536;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.goal_y = 32'sd65536;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.goal_y = -32'sd65536; r.robot_heading = -16'sd25736;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.goal_x = -32'sd65536; r.goal_y = -32'sd1;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.robot_heading = 16'sh7FFF; r.goal_x = 32'sd5;
    directed.push_back('{r, 1'b0, zero_res});
    r.robot_heading = 16'sh8000;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.robot_x = 32'sh8000_0000; r.robot_y = 32'sh8000_0000;
    r.goal_x = 32'sh7FFF_FFFF; r.goal_y = 32'sh7FFF_FFFF;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.robot_x = 32'sh7FFF_FFFF; r.goal_x = 32'sh8000_0000;
    r.robot_y = 32'sh7FFF_FFFF; r.goal_y = 32'sh8000_0000;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.robot_x = 32'sh8000_0000; r.goal_x = 32'sh7FFF_FFFF;
    directed.push_back('{r, 1'b0, zero_res});
    r = '0; r.robot_x = -32'sd1; r.robot_y = -32'sd1; r.robot_heading = -16'sd1;
    directed.push_back('{r, 1'b0, zero_res});

    foreach (directed[i]) send_request(directed[i].req, directed[i].has_expect,
                                       directed[i].result);
    start <= 1'b0;
    drain_results();

    // max gain so extreme offsets saturate
    write_gain(16'hFFFF);
    foreach (directed[i]) send_request(directed[i].req, 1'b0, zero_res);
    start <= 1'b0;
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_gain(16'd0); idle_pct = 0; end
        1: begin write_gain(16'd256); idle_pct = 75; end
        2: begin write_gain(16'($urandom)); idle_pct = 0; end
        3: begin write_gain(16'd1); idle_pct = 33; end
        4: begin write_gain(16'hFFFF); idle_pct = 75; end
        default: begin write_gain(gtg_pkg::GAIN_RESET); idle_pct = 0; end
      endcase
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        send_request(random_request($urandom_range(5)), 1'b0, zero_res);
        if (phase == 2 && n == 100) begin
          start <= 1'b0;
          while (drive_queue.size() != 0) @(negedge clk);
        end
      end
      start <= 1'b0;
      drain_results();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
